### src/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// Holds the command word passed from the front end to the back end through the queue.
// No dependencies.
package jse_pkg;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RAW,
      KIND_ESC,
      KIND_HEX
   } body_kind_type;

   typedef struct packed {
      logic            quote_open;
      logic [2:0]      repl_count;
      body_kind_type   kind;
      logic [2:0]      raw_length;
      logic [3:0][7:0] data;
      logic            quote_close;
   } command_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_D         = 8'h64;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   localparam logic [2:0] ESC_LENGTH  = 3'd2;
   localparam logic [2:0] HEX_LENGTH  = 3'd6;
   localparam logic [2:0] REPL_LENGTH = 3'd6;

   localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
   localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;
   localparam logic [20:0] CP_SURR_LOW   = 21'h00d800;
   localparam logic [20:0] CP_SURR_HIGH  = 21'h00dfff;
   localparam logic [20:0] CP_MAX        = 21'h10ffff;

   localparam logic [0:0] REG_STRICT_MODE = 1'b0;

   function automatic logic [7:0] hex_digit(input logic [3:0] value);
      logic [7:0] wide;
      wide = {4'h0, value};
      if (value < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return 8'h57 + wide;
   endfunction

endpackage

### src/jse_front.sv
// Front end of the JSON string escaper: accepts words, tracks UTF-8 sequences
// and turns each word into at most one command for the back end.
// Depends on jse_pkg.
module jse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 strict_mode,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [7:0]           req_in_byte,
   input  logic                 queue_full,
   output logic                 push,
   output jse_pkg::command_type command
);

   logic            inside_ff, inside_in;
   logic [7:0]      held_ff [3];
   logic [7:0]      held_in [3];
   logic [1:0]      held_count_ff, held_count_in;
   logic [2:0]      seq_length_ff, seq_length_in;
   logic [20:0]     code_point_ff, code_point_in;

   logic            accept;
   logic            fresh;
   logic [2:0]      repl_pre;
   logic [2:0]      count_next;
   logic [20:0]     code_next;
   logic            bad;
   logic [7:0]      b;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;

   assign count_next = {1'b0, held_count_ff} + 3'd1;
   assign code_next  = {code_point_ff[14:0], b[5:0]};
   assign bad = (seq_length_ff == 3'd3 && code_next < jse_pkg::CP_MIN_3BYTE) ||
                (seq_length_ff == 3'd4 && code_next < jse_pkg::CP_MIN_4BYTE) ||
                (code_next >= jse_pkg::CP_SURR_LOW && code_next <= jse_pkg::CP_SURR_HIGH) ||
                (code_next > jse_pkg::CP_MAX);

   always_comb begin
      inside_in     = inside_ff;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      seq_length_in = seq_length_ff;
      code_point_in = code_point_ff;
      command       = '0;
      command.quote_open = !inside_ff;
      fresh    = 1'b0;
      repl_pre = 3'd0;
      if (req_operation) begin
         command.repl_count  = {1'b0, held_count_ff};
         command.quote_close = 1'b1;
         inside_in     = 1'b0;
         held_count_in = 2'd0;
         seq_length_in = 3'd0;
         code_point_in = '0;
      end else begin
         inside_in = 1'b1;
         if (held_count_ff == 2'd0) begin
            fresh = 1'b1;
         end else if (b[7:6] != 2'b10) begin
            repl_pre      = {1'b0, held_count_ff};
            fresh         = 1'b1;
            held_count_in = 2'd0;
            seq_length_in = 3'd0;
            code_point_in = '0;
         end else begin
            code_point_in = code_next;
            if (count_next < seq_length_ff) begin
               held_in[held_count_ff] = b;
               held_count_in = count_next[1:0];
            end else begin
               held_count_in = 2'd0;
               seq_length_in = 3'd0;
               code_point_in = '0;
               if (bad) begin
                  command.repl_count = seq_length_ff;
               end else begin
                  command.kind       = jse_pkg::KIND_RAW;
                  command.raw_length = seq_length_ff;
                  command.data[0]    = held_ff[0];
                  command.data[1]    = (seq_length_ff == 3'd2) ? b : held_ff[1];
                  command.data[2]    = (seq_length_ff == 3'd3) ? b : held_ff[2];
                  command.data[3]    = b;
               end
            end
         end
         if (fresh) begin
            command.repl_count = repl_pre;
            case (b)
               jse_pkg::CHAR_QUOTE: begin
                  command.kind    = jse_pkg::KIND_ESC;
                  command.data[0] = jse_pkg::CHAR_QUOTE;
               end
               jse_pkg::CHAR_BACKSLASH: begin
                  command.kind    = jse_pkg::KIND_ESC;
                  command.data[0] = jse_pkg::CHAR_BACKSLASH;
               end
               jse_pkg::CHAR_LF: begin
                  command.kind    = jse_pkg::KIND_ESC;
                  command.data[0] = jse_pkg::CHAR_N;
               end
               jse_pkg::CHAR_CR: begin
                  command.kind    = jse_pkg::KIND_ESC;
                  command.data[0] = jse_pkg::CHAR_R;
               end
               jse_pkg::CHAR_TAB: begin
                  command.kind    = jse_pkg::KIND_ESC;
                  command.data[0] = jse_pkg::CHAR_T;
               end
               default: begin
                  if (b < 8'h20) begin
                     command.kind    = jse_pkg::KIND_HEX;
                     command.data[0] = b;
                  end else if (!b[7] || !strict_mode) begin
                     command.kind       = jse_pkg::KIND_RAW;
                     command.raw_length = 3'd1;
                     command.data[0]    = b;
                  end else if (b >= 8'hc2 && b <= 8'hdf) begin
                     seq_length_in = 3'd2;
                     code_point_in = {16'h0, b[4:0]};
                     held_in[0]    = b;
                     held_count_in = 2'd1;
                  end else if (b >= 8'he0 && b <= 8'hef) begin
                     seq_length_in = 3'd3;
                     code_point_in = {17'h0, b[3:0]};
                     held_in[0]    = b;
                     held_count_in = 2'd1;
                  end else if (b >= 8'hf0 && b <= 8'hf4) begin
                     seq_length_in = 3'd4;
                     code_point_in = {18'h0, b[2:0]};
                     held_in[0]    = b;
                     held_count_in = 2'd1;
                  end else begin
                     command.repl_count = repl_pre + 3'd1;
                  end
               end
            endcase
         end
      end
   end

   assign push = accept && (command.quote_open || command.repl_count != 3'd0 ||
                            command.kind != jse_pkg::KIND_NONE || command.quote_close);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         held_count_ff <= 2'd0;
         seq_length_ff <= 3'd0;
         code_point_ff <= '0;
      end else if (accept) begin
         inside_ff     <= inside_in;
         held_count_ff <= held_count_in;
         seq_length_ff <= seq_length_in;
         code_point_ff <= code_point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_held_inside: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> inside_ff)
      else $error("held bytes outside an open string");

   a_held_short: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> {1'b0, held_count_ff} < seq_length_ff)
      else $error("held count reached the sequence length");

endmodule

### src/jse_queue.sv
// Short command queue between the front end and the back end of the escaper.
// Depends on jse_pkg for the command word.
module jse_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jse_pkg::command_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output jse_pkg::command_type head_data
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   jse_pkg::command_type entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   do_push, do_pop;

   assign full       = count_ff == FULL_COUNT;
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/jse_back.sv
// Back end of the escaper: expands one command at a time into output words,
// one byte per cycle while rsp_ready does not stall it, into a registered output stage.
// Depends on jse_pkg.
module jse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  jse_pkg::command_type head_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_string_done
);

   typedef enum logic [1:0] {
      PH_OPEN,
      PH_REPL,
      PH_BODY,
      PH_CLOSE
   } phase_type;

   function automatic logic [3:0] present_of(input jse_pkg::command_type c);
      return {c.quote_close, c.kind != jse_pkg::KIND_NONE, c.repl_count != 3'd0, c.quote_open};
   endfunction

   function automatic logic [2:0] first_from(input logic [3:0] present, input logic [2:0] start);
      logic       found;
      logic [1:0] idx;
      found = 1'b0;
      idx   = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (!found && present[i] && 3'(i) >= start) begin
            found = 1'b1;
            idx   = 2'(i);
         end
      end
      return {found, idx};
   endfunction

   jse_pkg::command_type cur_ff;
   logic                 cur_valid_ff;
   phase_type            phase_ff;
   logic [2:0]           repl_idx_ff;
   logic [2:0]           char_idx_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;
   logic                 rsp_done_ff;

   logic       advance;
   logic       phase_end;
   logic       is_last;
   logic [2:0] after;
   logic [2:0] first;
   logic [2:0] body_length;
   logic [7:0] cur_byte;

   assign advance = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign after   = first_from(present_of(cur_ff), {1'b0, phase_ff} + 3'd1);
   assign first   = first_from(present_of(head_data), 3'd0);
   assign pop     = head_valid && (!cur_valid_ff || (advance && is_last));
   assign is_last = phase_end && !after[2];

   always_comb begin
      case (cur_ff.kind)
         jse_pkg::KIND_RAW: body_length = cur_ff.raw_length;
         jse_pkg::KIND_ESC: body_length = jse_pkg::ESC_LENGTH;
         jse_pkg::KIND_HEX: body_length = jse_pkg::HEX_LENGTH;
         default:           body_length = 3'd1;
      endcase
   end

   always_comb begin
      phase_end = 1'b1;
      cur_byte  = jse_pkg::CHAR_QUOTE;
      case (phase_ff)
         PH_REPL: begin
            phase_end = (char_idx_ff == jse_pkg::REPL_LENGTH - 3'd1) &&
                        (repl_idx_ff == cur_ff.repl_count - 3'd1);
            case (char_idx_ff)
               3'd0:    cur_byte = jse_pkg::CHAR_BACKSLASH;
               3'd1:    cur_byte = jse_pkg::CHAR_U;
               3'd2:    cur_byte = jse_pkg::CHAR_F;
               3'd3:    cur_byte = jse_pkg::CHAR_F;
               3'd4:    cur_byte = jse_pkg::CHAR_F;
               default: cur_byte = jse_pkg::CHAR_D;
            endcase
         end
         PH_BODY: begin
            phase_end = char_idx_ff == body_length - 3'd1;
            case (cur_ff.kind)
               jse_pkg::KIND_RAW: cur_byte = cur_ff.data[char_idx_ff[1:0]];
               jse_pkg::KIND_ESC: begin
                  cur_byte = (char_idx_ff == 3'd0) ? jse_pkg::CHAR_BACKSLASH : cur_ff.data[0];
               end
               default: begin
                  case (char_idx_ff)
                     3'd0:    cur_byte = jse_pkg::CHAR_BACKSLASH;
                     3'd1:    cur_byte = jse_pkg::CHAR_U;
                     3'd2:    cur_byte = jse_pkg::CHAR_ZERO;
                     3'd3:    cur_byte = jse_pkg::CHAR_ZERO;
                     3'd4:    cur_byte = jse_pkg::hex_digit(cur_ff.data[0][7:4]);
                     default: cur_byte = jse_pkg::hex_digit(cur_ff.data[0][3:0]);
                  endcase
               end
            endcase
         end
         default: begin
            phase_end = 1'b1;
            cur_byte  = jse_pkg::CHAR_QUOTE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_OPEN;
         repl_idx_ff  <= 3'd0;
         char_idx_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= cur_byte;
            rsp_last_ff  <= is_last;
            rsp_done_ff  <= phase_ff == PH_CLOSE;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            cur_valid_ff <= 1'b1;
            cur_ff       <= head_data;
            phase_ff     <= phase_type'(first[1:0]);
            repl_idx_ff  <= 3'd0;
            char_idx_ff  <= 3'd0;
         end else if (advance && is_last) begin
            cur_valid_ff <= 1'b0;
         end else if (advance) begin
            if (phase_end) begin
               phase_ff    <= phase_type'(after[1:0]);
               repl_idx_ff <= 3'd0;
               char_idx_ff <= 3'd0;
            end else if (phase_ff == PH_REPL &&
                         char_idx_ff == jse_pkg::REPL_LENGTH - 3'd1) begin
               repl_idx_ff <= repl_idx_ff + 3'd1;
               char_idx_ff <= 3'd0;
            end else begin
               char_idx_ff <= char_idx_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_string_done = rsp_done_ff;

   a_repl_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && phase_ff == PH_REPL |-> repl_idx_ff < cur_ff.repl_count)
      else $error("replacement index ran past its count");

   a_body_kind: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && phase_ff == PH_BODY |-> cur_ff.kind != jse_pkg::KIND_NONE)
      else $error("body phase entered without a body");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff)
      else $error("closing quote is not the last word of its item");

endmodule

### src/json_string_escaper_utf8.sv
// Top level of the JSON string escaper with UTF-8 validation.
// Instantiates jse_front, jse_queue and jse_back; depends on jse_pkg.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_operation, req_in_byte
//   rsp       out        rsp_valid / rsp_ready   rsp_out_byte, rsp_run_last, rsp_string_done
//   csr       in         psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// The back end emits one output byte per cycle while rsp_ready does not stall it; an item
// produces up to 24 bytes, and plain bytes flow at one per cycle while not stalled.
// From idle, an accepted item goes through the queue and cur_ff into the output register.
// The front end takes an item in every cycle while the command queue has room.
// Reset is synchronous; after it strict_mode is 1 and no string is open.
// A stalled rsp_ready holds the output register; the queue then fills and drops req_ready.
module json_string_escaper_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 strict_mode_ff;
   logic                 queue_full;
   logic                 push;
   jse_pkg::command_type command;
   logic                 pop;
   logic                 head_valid;
   jse_pkg::command_type head_data;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == jse_pkg::REG_STRICT_MODE) ? {31'h0, strict_mode_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_mode_ff <= 1'b1;
      end else if (psel && penable && pwrite && paddr[2] == jse_pkg::REG_STRICT_MODE) begin
         strict_mode_ff <= pwdata[0];
      end
   end

   jse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .strict_mode   (strict_mode_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_in_byte   (req_in_byte),
      .queue_full    (queue_full),
      .push          (push),
      .command       (command)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (command),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   jse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

endmodule

### dv/tb.sv
// Self-checking testbench for json_string_escaper_utf8: string bytes go in, JSON text comes out.
// Predicts each output word in step with accepted input words and compares them in order.
// Depends on jse_pkg and the RTL of json_string_escaper_utf8.
`timescale 1ns / 1ps

module tb;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;
   localparam logic [2:0] STRICT_ADDR = {jse_pkg::REG_STRICT_MODE, 2'b00};
   localparam int DRAIN_CYCLES    = 32;
   localparam int STALL_LIMIT     = 4000;
   localparam int RANDOM_SEGMENTS = 8;
   localparam int SEGMENT_ITEMS   = 62;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       done;
   } json_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   json_char_type escaped_q[$];
   int          step_chars = 0;
   int          errors = 0;
   int          sent_items = 0;
   int          idle_cycles = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          gap_by_phase[4] = '{0, 55, 0, 26};
   int          stall_by_phase[4] = '{0, 0, 55, 26};

   logic        strict_shadow = 1'b1;
   logic        str_open = 1'b0;
   logic [7:0]  held_byte[3];
   int          held_n = 0;
   int          seq_n = 0;
   logic [20:0] code_pt = 21'd0;

   json_string_escaper_utf8 i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_string_done(rsp_string_done),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic void push_char(input logic [7:0] c, input logic done);
      escaped_q.push_back('{ch: c, last: 1'b0, done: done});
      step_chars++;
   endfunction

   function automatic void push_replacement();
      push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
      push_char(jse_pkg::CHAR_U, 1'b0);
      push_char(jse_pkg::CHAR_F, 1'b0);
      push_char(jse_pkg::CHAR_F, 1'b0);
      push_char(jse_pkg::CHAR_F, 1'b0);
      push_char(jse_pkg::CHAR_D, 1'b0);
   endfunction

   function automatic void clear_held();
      held_n = 0;
      seq_n = 0;
      code_pt = 21'd0;
   endfunction

   function automatic void flush_held();
      repeat (held_n) push_replacement();
      clear_held();
   endfunction

   function automatic void escape_fresh(input logic [7:0] b);
      logic [7:0] lo;
      lo = {4'h0, b[3:0]};
      case (b)
         jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_BACKSLASH: begin
            push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
            push_char(b, 1'b0);
         end
         jse_pkg::CHAR_LF: begin
            push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
            push_char(jse_pkg::CHAR_N, 1'b0);
         end
         jse_pkg::CHAR_CR: begin
            push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
            push_char(jse_pkg::CHAR_R, 1'b0);
         end
         jse_pkg::CHAR_TAB: begin
            push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
            push_char(jse_pkg::CHAR_T, 1'b0);
         end
         default: begin
            if (b < 8'h20) begin
               push_char(jse_pkg::CHAR_BACKSLASH, 1'b0);
               push_char(jse_pkg::CHAR_U, 1'b0);
               push_char(jse_pkg::CHAR_ZERO, 1'b0);
               push_char(jse_pkg::CHAR_ZERO, 1'b0);
               push_char(jse_pkg::CHAR_ZERO + {7'd0, b[4]}, 1'b0);
               push_char((lo < 8'd10) ? jse_pkg::CHAR_ZERO + lo : 8'h61 + lo - 8'd10, 1'b0);
            end else if (b < 8'h80 || !strict_shadow) begin
               push_char(b, 1'b0);
            end else begin
               if (b >= 8'hc2 && b <= 8'hdf) begin
                  seq_n = 2;
                  code_pt = {16'd0, b[4:0]};
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  seq_n = 3;
                  code_pt = {17'd0, b[3:0]};
               end else if (b >= 8'hf0 && b <= 8'hf4) begin
                  seq_n = 4;
                  code_pt = {18'd0, b[2:0]};
               end else begin
                  push_replacement();
               end
               if (seq_n != 0) begin
                  held_byte[0] = b;
                  held_n = 1;
               end
            end
         end
      endcase
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      logic bad;
      if (held_n == 0) begin
         escape_fresh(b);
         return;
      end
      if (b[7:6] != 2'b10) begin
         flush_held();
         escape_fresh(b);
         return;
      end
      code_pt = {code_pt[14:0], b[5:0]};
      if (held_n < 3) held_byte[held_n] = b;
      held_n++;
      if (held_n < seq_n) return;
      bad = (seq_n == 3 && code_pt < jse_pkg::CP_MIN_3BYTE) ||
            (seq_n == 4 && code_pt < jse_pkg::CP_MIN_4BYTE) ||
            (code_pt >= jse_pkg::CP_SURR_LOW && code_pt <= jse_pkg::CP_SURR_HIGH) ||
            (code_pt > jse_pkg::CP_MAX);
      if (bad) begin
         repeat (seq_n) push_replacement();
      end else begin
         for (int i = 0; i < seq_n - 1; i++) push_char(held_byte[i], 1'b0);
         push_char(b, 1'b0);
      end
      clear_held();
   endfunction

   function automatic void predict_escape(input logic op, input logic [7:0] b);
      json_char_type tail;
      step_chars = 0;
      if (!str_open) begin
         push_char(jse_pkg::CHAR_QUOTE, 1'b0);
         str_open = 1'b1;
      end
      if (op == OP_BYTE) begin
         take_byte(b);
      end else begin
         flush_held();
         push_char(jse_pkg::CHAR_QUOTE, 1'b1);
         str_open = 1'b0;
      end
      if (step_chars > 0) begin
         tail = escaped_q.pop_back();
         tail.last = 1'b1;
         escaped_q.push_back(tail);
      end
   endfunction

   task automatic send_word(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_escape(op, b);
      sent_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (escaped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_strict_mode(input logic mode);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= STRICT_ADDR;
      pwdata <= {31'd0, mode};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      strict_shadow = mode;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_random_char();
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      int         len;
      int         pick;
      int         k;
      pick = $urandom_range(19);
      len = 0;
      lo = 8'h80;
      hi = 8'hbf;
      if (pick < 8) begin
         send_word(OP_BYTE, 8'($urandom_range(8'h7e, 8'h20)));
      end else if (pick < 10) begin
         send_word(OP_BYTE, 8'($urandom_range(8'h1f)));
      end else if (pick < 12) begin
         lead = 8'($urandom_range(8'hdf, 8'hc2));
         len = 2;
      end else if (pick < 14) begin
         lead = 8'($urandom_range(8'hef, 8'he0));
         if (lead == 8'he0) lo = 8'ha0;
         if (lead == 8'hed) hi = 8'h9f;
         len = 3;
      end else if (pick == 14) begin
         lead = 8'($urandom_range(8'hf4, 8'hf0));
         if (lead == 8'hf0) lo = 8'h90;
         if (lead == 8'hf4) hi = 8'h8f;
         len = 4;
      end else if (pick == 15) begin
         // Complete sequences that must be rejected: overlong, surrogate, beyond U+10FFFF.
         k = $urandom_range(3);
         case (k)
            0: begin lead = 8'he0; hi = 8'h9f; len = 3; end
            1: begin lead = 8'hed; lo = 8'ha0; len = 3; end
            2: begin lead = 8'hf0; hi = 8'h8f; len = 4; end
            default: begin lead = 8'hf4; lo = 8'h90; len = 4; end
         endcase
      end else if (pick == 16) begin
         // A sequence cut short; the next word breaks it unless it is a continuation byte.
         lead = 8'($urandom_range(8'hf4, 8'hc2));
         len = 1 + $urandom_range((lead >= 8'hf0) ? 2 : (lead >= 8'he0) ? 1 : 0);
      end else if (pick == 17) begin
         if ($urandom_range(1) == 0) send_word(OP_BYTE, 8'($urandom_range(8'hc1, 8'h80)));
         else send_word(OP_BYTE, 8'($urandom_range(8'hff, 8'hf5)));
      end else begin
         send_word(OP_BYTE, 8'($urandom_range(255)));
      end
      if (len > 0) begin
         send_word(OP_BYTE, lead);
         if (len > 1) send_word(OP_BYTE, 8'($urandom_range(hi, lo)));
         for (int i = 2; i < len; i++) send_word(OP_BYTE, 8'($urandom_range(8'hbf, 8'h80)));
      end
   endtask

   task automatic test_escapes();
      logic [8:0] items[$];
      items = '{{OP_END, 8'h5a}, {OP_BYTE, 8'h22}, {OP_BYTE, 8'h5c}, {OP_BYTE, 8'h0a},
                {OP_BYTE, 8'h0d}, {OP_BYTE, 8'h09}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h1f},
                {OP_BYTE, 8'h7f}, {OP_BYTE, 8'h20}, {OP_END, 8'h00}};
      foreach (items[i]) send_word(items[i][8], items[i][7:0]);
   endtask

   task automatic test_utf8_cases();
      logic [8:0] items[$];
      items = '{{OP_BYTE, 8'h80}, {OP_BYTE, 8'hf5}, {OP_BYTE, 8'hc2}, {OP_BYTE, 8'h80},
                {OP_BYTE, 8'he0}, {OP_BYTE, 8'h80}, {OP_BYTE, 8'h80},
                {OP_BYTE, 8'hed}, {OP_BYTE, 8'ha0}, {OP_BYTE, 8'h80},
                {OP_BYTE, 8'hf4}, {OP_BYTE, 8'h90}, {OP_BYTE, 8'h80}, {OP_BYTE, 8'h80},
                {OP_BYTE, 8'he2}, {OP_BYTE, 8'h82}, {OP_BYTE, 8'h41},
                {OP_BYTE, 8'hf0}, {OP_BYTE, 8'h90}, {OP_END, 8'hff}};
      foreach (items[i]) send_word(items[i][8], items[i][7:0]);
   endtask

   task automatic test_mode_change();
      send_word(OP_BYTE, 8'he2);
      send_word(OP_BYTE, 8'h82);
      wait_idle();
      write_strict_mode(1'b0);
      send_word(OP_BYTE, 8'hac);
      send_word(OP_BYTE, 8'he9);
      wait_idle();
      write_strict_mode(1'b1);
      send_word(OP_BYTE, 8'hf0);
      send_word(OP_BYTE, 8'h90);
      wait_idle();
      write_strict_mode(1'b0);
      send_word(OP_BYTE, 8'h41);
      send_word(OP_END, 8'h00);
      wait_idle();
      write_strict_mode(1'b1);
   endtask

   task automatic test_random_text(input int n, input int gap, input int stall);
      int stop;
      req_gap_pct = gap;
      rsp_stall_pct = stall;
      stop = sent_items + n;
      while (sent_items < stop) begin
         if ($urandom_range(9) == 0) send_word(OP_END, 8'($urandom));
         else send_random_char();
      end
   endtask

   always @(posedge clock) begin : check_output
      json_char_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (escaped_q.size() == 0) begin
            if (errors < 10) begin
               $display("unexpected word: byte %h last %b done %b",
                        rsp_out_byte, rsp_run_last, rsp_string_done);
            end
            errors++;
         end else begin
            want = escaped_q.pop_front();
            if (rsp_out_byte !== want.ch || rsp_run_last !== want.last ||
                rsp_string_done !== want.done) begin
               if (errors < 10) begin
                  $display("mismatch: expected byte %h last %b done %b, %s",
                           want.ch, want.last, want.done, "got:");
                  $display("   byte %h last %b done %b",
                           rsp_out_byte, rsp_run_last, rsp_string_done);
               end
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escapes();
      test_utf8_cases();
      test_mode_change();
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         test_random_text(SEGMENT_ITEMS, gap_by_phase[seg % 4], stall_by_phase[seg % 4]);
         wait_idle();
         write_strict_mode(seg % 3 != 1);
      end
      wait_idle();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
